### design/flna_pkg.sv
// flna_pkg: widths, fixed-point constants and the sideband struct shared by
// the natural log pipeline. Depends on nothing; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package flna_pkg;

    // port widths
    localparam int X_W  = 32;
    localparam int LN_W = 32;

    // float32 layout
    localparam int EXP_W     = 8;
    localparam int MANT_FRAC = 23;
    localparam int MANT_W    = MANT_FRAC + 1;
    localparam logic [EXP_W-1:0] EXP_MAX = 8'd255;
    localparam logic [EXP_W-1:0] EXP_ZERO = 8'd0;
    localparam int EXP_BIAS  = 127;

    // fixed-point formats
    localparam int FRAC_BITS = 24;
    localparam int INT_FRAC  = 30;
    localparam int OUT_SHIFT = INT_FRAC - FRAC_BITS;

    // horner accumulator: q30, magnitude stays below 4
    localparam int ACC_W  = 34;
    localparam int PROD_W = ACC_W + MANT_W + 1;

    // exponent term and final sum
    localparam int ESGN_W = EXP_W + 1;
    localparam int LN2_W  = 31;
    localparam int EMUL_W = ESGN_W + LN2_W;
    localparam int TOT_W  = EMUL_W + 1;

    localparam logic signed [ACC_W-1:0] COEF_C0 = ACC_W'(-64'sd1870236959);
    localparam logic signed [ACC_W-1:0] COEF_C1 = ACC_W'(64'sd3029243226);
    localparam logic signed [ACC_W-1:0] COEF_C2 = ACC_W'(-64'sd1578354096);
    localparam logic signed [ACC_W-1:0] COEF_C3 = ACC_W'(64'sd480155386);
    localparam logic signed [ACC_W-1:0] COEF_C4 = ACC_W'(64'sd60742489);
    localparam logic signed [LN2_W-1:0] LN2_Q30 = LN2_W'(64'sd744261118);

    localparam logic signed [TOT_W-1:0] SAT_MAX = TOT_W'(64'sd2147483647);
    localparam logic signed [TOT_W-1:0] SAT_MIN = TOT_W'(-64'sd2147483648);

    // horner steps: step k adds (or subtracts) round(acc * m) to STEP_COEF[k]
    localparam int N_STEPS = 4;
    localparam logic signed [ACC_W-1:0] STEP_COEF [N_STEPS] =
        '{COEF_C3, COEF_C2, COEF_C1, COEF_C0};
    localparam logic [N_STEPS-1:0] STEP_SUB = N_STEPS'(1);

    // data that rides along with each item through the pipeline
    typedef struct packed {
        logic              invalid;
        logic [EXP_W-1:0]  exp_field;
        logic [MANT_W-1:0] mant;
    } t_side;

endpackage

`default_nettype wire

### design/flna_if.sv
// flna_if: valid/ready channel interfaces for input bit patterns and log results.
// Depends on flna_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface flna_in_if;
    logic                      valid;
    logic                      ready;
    logic [flna_pkg::X_W-1:0]  x_bits;

    modport source (output valid, output x_bits, input ready);
    modport sink   (input valid, input x_bits, output ready);
endinterface

interface flna_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [flna_pkg::LN_W-1:0]  ln_value;
    logic                              invalid;

    modport source (output valid, output ln_value, output invalid, input ready);
    modport sink   (input valid, input ln_value, input invalid, output ready);
endinterface

`default_nettype wire

### design/flna_horner_step.sv
// flna_horner_step: one horner step over two register stages, multiply by the
// mantissa then round and add to or subtract from the coefficient. Depends on flna_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flna_horner_step (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [flna_pkg::ACC_W-1:0] i_acc,
    input  wire flna_pkg::t_side                   i_side,
    input  wire logic signed [flna_pkg::ACC_W-1:0] i_coef,
    input  wire logic                              i_sub,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [flna_pkg::ACC_W-1:0]      o_acc,
    output flna_pkg::t_side                        o_side
);
    import flna_pkg::*;

    logic                      r_a_valid;
    logic signed [PROD_W-1:0]  r_a_prod;
    t_side                     r_a_side;
    logic                      r_b_valid;
    logic signed [ACC_W-1:0]   r_b_acc;
    t_side                     r_b_side;

    logic                      a_ready;
    logic                      b_ready;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]   w_q;
    logic signed [ACC_W-1:0]   n_acc;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    always_comb begin
        n_prod = PROD_W'(i_acc) * PROD_W'($signed({1'b0, i_side.mant}));
    end

    // round to nearest, tie toward plus infinity, back to q30
    always_comb begin
        w_rnd = (r_a_prod + (PROD_W'(1) <<< (MANT_FRAC - 1))) >>> MANT_FRAC;
        w_q   = $signed(w_rnd[ACC_W-1:0]);
        n_acc = i_sub ? (i_coef - w_q) : (i_coef + w_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_prod <= n_prod;
            r_a_side <= i_side;
        end
        if (b_ready) begin
            r_b_acc  <= n_acc;
            r_b_side <= r_a_side;
        end
    end

    assign o_valid = r_b_valid;
    assign o_acc   = r_b_acc;
    assign o_side  = r_b_side;

endmodule

`default_nettype wire

### design/float_natural_log_approx_top.sv
// float_natural_log_approx_top: pipelined ln() of a float32 bit pattern into
// signed fixed point. Depends on flna_pkg, flna_if and flna_horner_step.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | dir | payload                          | accepted when
//  i_in     | in  | x_bits[31:0]                     | i_in.valid && i_in.ready
//  o_out    | out | ln_value[31:0] (signed), invalid | o_out.valid && o_out.ready
//
//  one item per cycle sustained while o_out is ready; twelve register stages
//  (input register, four horner steps of two stages, exponent multiply, final
//  sum, round/saturate output register), and a result is offered once its item
//  has passed through all of them
//  every stage has its own valid bit and loads whenever it is empty or the
//  stage after it moves, so a stall at o_out fills bubbles before i_in stops
//  i_rst_n (synchronous, active low) clears all valid bits; data is not reset

module float_natural_log_approx_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    flna_in_if.sink      i_in,
    flna_out_if.source   o_out
);
    import flna_pkg::*;

    // input register: field decode and mantissa with hidden one
    logic                      r_s0_valid;
    t_side                     r_s0_side;
    logic                      s0_ready;
    t_side                     n_s0_side;

    // horner chain, index 0 feeds the first step
    logic                      w_valid [N_STEPS+1];
    logic                      w_ready [N_STEPS+1];
    logic signed [ACC_W-1:0]   w_acc   [N_STEPS+1];
    t_side                     w_side  [N_STEPS+1];

    // exponent times ln2, polynomial carried alongside
    logic                      r_s9_valid;
    logic signed [EMUL_W-1:0]  r_s9_emul;
    logic signed [ACC_W-1:0]   r_s9_p;
    logic                      r_s9_invalid;
    logic                      s9_ready;
    logic signed [ESGN_W-1:0]  w_exp;
    logic signed [EMUL_W-1:0]  n_emul;

    // full q30 sum
    logic                      r_s10_valid;
    logic signed [TOT_W-1:0]   r_s10_total;
    logic                      r_s10_invalid;
    logic                      s10_ready;
    logic signed [TOT_W-1:0]   n_total;

    // output register
    logic                      r_o_valid;
    logic signed [LN_W-1:0]    r_o_ln;
    logic                      r_o_invalid;
    logic                      o_stage_ready;
    logic signed [TOT_W-1:0]   w_round;
    logic signed [LN_W-1:0]    n_ln;

    // ---------------- input stage ----------------
    // sign set, exponent field all zeros or all ones: no handled logarithm
    always_comb begin
        n_s0_side.exp_field = i_in.x_bits[X_W-2 -: EXP_W];
        n_s0_side.mant      = {1'b1, i_in.x_bits[MANT_FRAC-1:0]};
        n_s0_side.invalid   = i_in.x_bits[X_W-1]
                              || (n_s0_side.exp_field == EXP_ZERO)
                              || (n_s0_side.exp_field == EXP_MAX);
    end

    assign s0_ready   = !r_s0_valid || w_ready[0];
    assign i_in.ready = s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready) begin
            r_s0_side <= n_s0_side;
        end
    end

    // ---------------- horner steps ----------------
    // first step starts from the top coefficient and subtracts: c3 - c4*m
    assign w_valid[0] = r_s0_valid;
    assign w_acc[0]   = COEF_C4;
    assign w_side[0]  = r_s0_side;

    for (genvar k = 0; k < N_STEPS; k++) begin : g_step
        flna_horner_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_acc   (w_acc[k]),
            .i_side  (w_side[k]),
            .i_coef  (STEP_COEF[k]),
            .i_sub   (STEP_SUB[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_acc   (w_acc[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    // ---------------- exponent term ----------------
    always_comb begin
        w_exp  = $signed({1'b0, w_side[N_STEPS].exp_field}) - ESGN_W'(EXP_BIAS);
        n_emul = EMUL_W'(w_exp) * EMUL_W'(LN2_Q30);
    end

    assign s9_ready         = !r_s9_valid || s10_ready;
    assign w_ready[N_STEPS] = s9_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_valid <= 1'b0;
        end else if (s9_ready) begin
            r_s9_valid <= w_valid[N_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s9_ready) begin
            r_s9_emul    <= n_emul;
            r_s9_p       <= w_acc[N_STEPS];
            r_s9_invalid <= w_side[N_STEPS].invalid;
        end
    end

    // ---------------- sum ----------------
    assign n_total   = TOT_W'(r_s9_emul) + TOT_W'(r_s9_p);
    assign s10_ready = !r_s10_valid || o_stage_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_valid <= 1'b0;
        end else if (s10_ready) begin
            r_s10_valid <= r_s9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s10_ready) begin
            r_s10_total   <= n_total;
            r_s10_invalid <= r_s9_invalid;
        end
    end

    // ---------------- round, saturate, output ----------------
    // round half up to FRAC_BITS, clamp to the signed 32-bit range
    always_comb begin
        w_round = (r_s10_total + (TOT_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (r_s10_invalid) begin
            n_ln = '0;
        end else if (w_round > SAT_MAX) begin
            n_ln = SAT_MAX[LN_W-1:0];
        end else if (w_round < SAT_MIN) begin
            n_ln = SAT_MIN[LN_W-1:0];
        end else begin
            n_ln = w_round[LN_W-1:0];
        end
    end

    assign o_stage_ready = !r_o_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_stage_ready) begin
            r_o_valid <= r_s10_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_stage_ready) begin
            r_o_ln      <= n_ln;
            r_o_invalid <= r_s10_invalid;
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.ln_value = r_o_ln;
    assign o_out.invalid  = r_o_invalid;

    // ---------------- checks ----------------
    // an accepted zero or subnormal is flagged in the input register
    a_zero_exp_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && (i_in.x_bits[X_W-2 -: EXP_W] == EXP_ZERO)
        |=> r_s0_valid && r_s0_side.invalid)
        else $error("zero exponent field not flagged invalid");

    // a valid decoded item always carries the hidden one
    a_hidden_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_valid && !r_s0_side.invalid |-> r_s0_side.mant[MANT_W-1])
        else $error("mantissa lost its hidden bit");

    // flagged results carry a zero value
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.invalid |-> (o_out.ln_value == '0))
        else $error("invalid result with nonzero value");

    // a held output stage does not change the sum stage behind a full register
    a_sum_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s10_valid && r_o_valid && !o_out.ready |=> r_s10_valid && $stable(r_s10_total))
        else $error("sum stage changed while output stalled");

endmodule

`default_nettype wire

### test/testbench.sv
// testbench: drives float32 bit patterns into float_natural_log_approx_top and
// checks every ln result against a fixed-point model kept here.
// Depends on flna_pkg, flna_if and the design sources.
`timescale 1ns / 1ps

typedef struct packed {
    logic signed [flna_pkg::LN_W-1:0] ln_value;
    logic                             invalid;
} ln_result_t;

// ln model of the block and the queue of results still owed by it
class ln_scoreboard;
    localparam int    HORNER_Q = 30;
    localparam int    MANT_Q   = 23;
    localparam longint K0      = -64'sd1870236959;
    localparam longint K1      = 64'sd3029243226;
    localparam longint K2      = -64'sd1578354096;
    localparam longint K3      = 64'sd480155386;
    localparam longint K4      = 64'sd60742489;
    localparam longint LN2_FX  = 64'sd744261118;
    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -64'sd2147483648;

    ln_result_t expected_ln_q[$];
    int n_errors;
    int n_checked;
    int n_invalid;

    function new();
        n_errors  = 0;
        n_checked = 0;
        n_invalid = 0;
    endfunction

    // divide by 2^s, ties up
    function longint round_q(longint v, int s);
        if (s == 0)
            return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function ln_result_t predict_ln(logic [31:0] x);
        logic [7:0] ef;
        longint     mant;
        longint     acc;
        longint     total;
        ln_result_t res;
        ef = x[30:23];
        res.ln_value = '0;
        res.invalid  = 1'b1;
        if (x[31] || ef == flna_pkg::EXP_ZERO || ef == flna_pkg::EXP_MAX)
            return res;
        mant  = longint'({1'b1, x[22:0]});
        acc   = K3 - round_q(K4 * mant, MANT_Q);
        acc   = K2 + round_q(acc * mant, MANT_Q);
        acc   = K1 + round_q(acc * mant, MANT_Q);
        acc   = K0 + round_q(acc * mant, MANT_Q);
        total = (longint'(ef) - flna_pkg::EXP_BIAS) * LN2_FX + acc;
        total = round_q(total, HORNER_Q - flna_pkg::FRAC_BITS);
        if (total > OUT_MAX)
            total = OUT_MAX;
        if (total < OUT_MIN)
            total = OUT_MIN;
        res.ln_value = total[31:0];
        res.invalid  = 1'b0;
        return res;
    endfunction

    function void record_x(logic [31:0] x);
        expected_ln_q.push_back(predict_ln(x));
    endfunction

    function void check_ln(logic signed [31:0] ln_value, logic invalid);
        ln_result_t want;
        if (expected_ln_q.size() == 0) begin
            $error("result with nothing pending: ln_value %0d invalid %0b", ln_value, invalid);
            n_errors++;
            return;
        end
        want = expected_ln_q.pop_front();
        n_checked++;
        if (want.invalid)
            n_invalid++;
        if (invalid !== want.invalid) begin
            $error("invalid: expected %0b, got %0b", want.invalid, invalid);
            n_errors++;
        end
        if (ln_value !== want.ln_value) begin
            $error("ln_value: expected %0d (%h), got %0d (%h)",
                   want.ln_value, want.ln_value, ln_value, ln_value);
            n_errors++;
        end
    endfunction

    function int pending();
        return expected_ln_q.size();
    endfunction
endclass

module testbench;
    import flna_pkg::*;

    // receiver stall modes
    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

    localparam int       N_PHASES    = 6;
    localparam int       PHASE_ITEMS = 305;
    localparam int       HOLD_CYCLES = 80;    // long enough to fill the 12-deep pipe
    localparam int       IDLE_LIMIT  = 2000;  // cycles with no item moving on either side
    localparam int       TAIL_CYCLES = 24;    // extra cycles run after the final drain
    localparam bit [6:0] RX_SHAPE    = 7'b1101001;

    logic i_clk;
    logic i_rst_n;

    flna_in_if  in_ch();
    flna_out_if out_ch();

    float_natural_log_approx_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ln_scoreboard sb = new();

    rx_mode_t rx_mode   = RX_ALWAYS;
    bit       hold_req  = 1'b0;   // ask the receiver for one long hold-off
    int       n_sent    = 0;
    int       n_holds   = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // both channels observed at the rising edge: accepted inputs feed the
    // model, accepted results are checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.record_x(in_ch.x_bits);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_ln(out_ch.ln_value, out_ch.invalid);
    end

    // receiver: ready follows the current stall mode, changes at the falling
    // edge; a hold request pulls ready low for a long stretch
    initial begin : receiver
        int rx_tick;
        rx_tick = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                n_holds++;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  out_ch.ready <= 1'b1;
                    RX_MOSTLY:  out_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE:  out_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_PATTERN: out_ch.ready <= RX_SHAPE[rx_tick % 7];
                    default:    out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // watchdog: ends the run if nothing moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // offer one item and hold it until it is taken; valid stays high so
    // back-to-back calls stream one item per cycle while the block is ready
    task automatic send_x(input logic [31:0] x);
        @(negedge i_clk);
        in_ch.valid  <= 1'b1;
        in_ch.x_bits <= x;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        n_sent++;
    endtask

    // sender gap, with junk on the data lines
    task automatic pause_sender(input int n);
        @(negedge i_clk);
        in_ch.valid  <= 1'b0;
        in_ch.x_bits <= $urandom;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // stop sending and wait for every owed result
    task automatic drain();
        pause_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // random items in bursts; mostly finite positive normals with the
    // specials (sign set, zero/subnormal exponent, inf/nan exponent) mixed in
    task automatic run_phase(input int n_items, input bit with_gaps);
        int          sent;
        int          burst;
        int          pick;
        logic [31:0] x;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                pick = $urandom_range(0, 99);
                x    = $urandom;
                if (pick < 82) begin
                    x[31] = 1'b0;
                    // half the time stay near 1.0 where the result is small
                    if (pick < 40)
                        x[30:23] = 8'($urandom_range(120, 134));
                    else
                        x[30:23] = 8'($urandom_range(1, 254));
                    // mantissa extremes now and then
                    if (pick % 10 == 0)
                        x[22:0] = '1;
                    else if (pick % 10 == 1)
                        x[22:0] = '0;
                end else if (pick < 88) begin
                    x[31] = 1'b1;
                end else if (pick < 93) begin
                    x[30:23] = EXP_ZERO;
                end else if (pick < 98) begin
                    x[30:23] = EXP_MAX;
                end
                send_x(x);
                sent++;
            end
            if (with_gaps && $urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    // main sequence
    initial begin
        logic [31:0] corner_x[$];
        int          n_directed;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.x_bits = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // corner patterns: signed zeros, subnormal edges, normal range ends,
        // infinities, nans, negatives, values around 1, 2, e and sqrt 2
        corner_x = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007F_FFFF,
                     32'h0080_0000, 32'h00FF_FFFF, 32'h7F7F_FFFF, 32'h7F00_0000,
                     32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                     32'hFFFF_FFFF, 32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0001,
                     32'h3F7F_FFFF, 32'h3FFF_FFFF, 32'h4000_0000, 32'h402D_F854,
                     32'h3FB5_04F3};
        n_directed = corner_x.size();
        foreach (corner_x[k])
            send_x(corner_x[k]);
        drain();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            rx_mode = rx_mode_t'((phase + 1) % 4);
            if (phase == 1) begin
                // long receiver hold-off while items keep coming, so the
                // pipeline fills and input ready drops
                hold_req = 1'b1;
                run_phase(120, 1'b0);
                run_phase(PHASE_ITEMS - 120, 1'b1);
            end else if (phase == 3) begin
                // sender waits mid-phase until everything has come back
                run_phase(PHASE_ITEMS / 2, 1'b1);
                drain();
                run_phase(PHASE_ITEMS - PHASE_ITEMS / 2, 1'b1);
            end else begin
                run_phase(PHASE_ITEMS, phase != 5);
            end
        end

        rx_mode = RX_ALWAYS;
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d items sent (%0d corner patterns), %0d results checked",
                 n_sent, n_directed, sb.n_checked);
        $display("run: %0d flagged invalid, %0d long receiver hold-offs",
                 sb.n_invalid, n_holds);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
